@@ sv/cro_pkg.sv @@
// cro_pkg: shared constants, widths and types for the camera relative offset unit
// no dependencies; imported by every module of the block
package cro_pkg;

  localparam int CELL_BITS     = 24;
  localparam int FRAC_BITS     = 16;
  localparam int LOCAL_BITS    = 32;
  localparam int CS_BITS       = 32;
  localparam int MAXD_BITS     = 48;
  localparam int REL_BITS      = 48;
  localparam int MANTISSA_BITS = 23;
  localparam int EXP_BITS      = 9;
  localparam int STEP_ZERO_EXP = -149;
  localparam int STEP_SAFE_EXP = -7;

  // per axis arithmetic
  localparam int DC_BITS    = CELL_BITS + 1;
  localparam int PROD_BITS  = DC_BITS + CS_BITS;
  localparam int CLAMP_LOG2 = 50;
  localparam int LD_BITS    = LOCAL_BITS + 1;
  localparam int SUM_BITS   = CLAMP_LOG2 + 3;
  localparam int LO_BITS    = 32;
  localparam int HI_BITS    = REL_BITS - LO_BITS;
  localparam int SQ_BITS    = 2 * REL_BITS;

  // root pipeline
  localparam int ROOT_BITS = REL_BITS + 1;
  localparam int RAD_BITS  = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 3;
  localparam int MSB_BITS  = $clog2(ROOT_BITS);

  localparam int EXP_BIAS = FRAC_BITS + MANTISSA_BITS;
  localparam int RISK_MSB = EXP_BIAS + STEP_SAFE_EXP;

  // stream widths
  localparam int IN_BITS  = 6 * CELL_BITS + 6 * LOCAL_BITS;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 3 * REL_BITS + MAXD_BITS + EXP_BITS + 2;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // configuration port
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = MAXD_BITS;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_CELL_SIZE = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_DIST  = 1'b1;

  // data carried alongside the root pipeline
  typedef struct packed {
    logic signed [REL_BITS-1:0] x;
    logic signed [REL_BITS-1:0] y;
    logic signed [REL_BITS-1:0] z;
    logic                       sat;
  } side_t;

endpackage

@@ sv/camera_relative_offset_unit.sv @@
// camera_relative_offset_unit: top level, three axis lanes, square sum, root pipeline, output skid
// depends on cro_pkg, cro_axis_lane and cro_sqrt_pipe
//
// Takes one transaction per clock while in_tready is high and returns one result per
// transaction, in order, after the axis lanes, the square sum, the root pipeline for the
// 49-bit root and the output register. The output register plus a one-entry skid buffer
// let the input keep flowing once more after the result side stalls; the whole pipeline
// then holds until the skid entry drains. Write cell_size and max_distance only while no
// transaction is in flight.
module camera_relative_offset_unit import cro_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // obj_cell_x/y/z, obj_local_x/y/z, cam_cell_x/y/z, cam_local_x/y/z from bit 0 up
  input  logic [IN_W-1:0]          in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // rel_x, rel_y, rel_z, distance, step_exponent, finite, precision_risk from bit 0 up, zero pad
  output logic [OUT_W-1:0]         out_tdata
);

  localparam int LANE_STAGES = 5;
  localparam int OC = 0;
  localparam int OL = 3 * CELL_BITS;
  localparam int CC = OL + 3 * LOCAL_BITS;
  localparam int CL = CC + 3 * CELL_BITS;

  logic [CS_BITS-1:0]   cell_size_r;
  logic [MAXD_BITS-1:0] max_dist_r;

  logic pipe_en;
  logic lane_vld_r [0:LANE_STAGES-1];

  logic signed [REL_BITS-1:0] rel [0:2];
  logic                       sat [0:2];
  logic [SQ_BITS-1:0]         sq  [0:2];

  logic                       m1_vld_r, m2_vld_r;
  logic [SQ_BITS-1:0]         sxy_m1_r, sqz_m1_r, s_m2_r;
  side_t                      side_m1_r, side_m2_r;

  logic                 sq_vld;
  logic [ROOT_BITS-1:0] root;
  logic                 rem_nz, root_nz;
  logic [MSB_BITS-1:0]  msb;
  side_t                side_o;

  logic                       zero_cs;
  logic [MAXD_BITS-1:0]       dist_val;
  logic signed [EXP_BITS-1:0] step_exp;
  logic                       finite, risk;
  logic [OUT_W-1:0]           res;

  logic             out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt, skid_data_r, skid_data_nxt;
  logic             take, push;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= CS_BITS'(67108864);
      max_dist_r  <= MAXD_BITS'(655360000);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CELL_SIZE: cell_size_r <= cfg_wdata[CS_BITS-1:0];
        CFG_MAX_DIST:  max_dist_r  <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // the pipeline moves whenever the skid entry is free
  assign pipe_en   = !skid_vld_r;
  assign in_tready = pipe_en;

  for (genvar a = 0; a < 3; a++) begin : g_lane
    cro_axis_lane u_lane (
      .clk       (clk),
      .en        (pipe_en),
      .cell_size (cell_size_r),
      .obj_cell  (in_tdata[OC + a*CELL_BITS +: CELL_BITS]),
      .cam_cell  (in_tdata[CC + a*CELL_BITS +: CELL_BITS]),
      .obj_local (in_tdata[OL + a*LOCAL_BITS +: LOCAL_BITS]),
      .cam_local (in_tdata[CL + a*LOCAL_BITS +: LOCAL_BITS]),
      .rel       (rel[a]),
      .sat       (sat[a]),
      .sq        (sq[a])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_STAGES; i++) lane_vld_r[i] <= 1'b0;
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
    end else if (pipe_en) begin
      lane_vld_r[0] <= in_tvalid;
      for (int i = 1; i < LANE_STAGES; i++) lane_vld_r[i] <= lane_vld_r[i-1];
      m1_vld_r <= lane_vld_r[LANE_STAGES-1];
      m2_vld_r <= m1_vld_r;
    end
  end

  // merge: sum of the three squares over two stages
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sxy_m1_r  <= sq[0] + sq[1];
      sqz_m1_r  <= sq[2];
      side_m1_r <= '{x: rel[0], y: rel[1], z: rel[2], sat: sat[0] | sat[1] | sat[2]};
      s_m2_r    <= sxy_m1_r + sqz_m1_r;
      side_m2_r <= side_m1_r;
    end
  end

  cro_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (m2_vld_r),
    .radicand (s_m2_r),
    .in_side  (side_m2_r),
    .out_vld  (sq_vld),
    .root     (root),
    .rem_nz   (rem_nz),
    .root_nz  (root_nz),
    .msb      (msb),
    .out_side (side_o)
  );

  // result fields
  always_comb begin
    zero_cs  = (cell_size_r == '0);
    dist_val = zero_cs ? '0 : root[MAXD_BITS-1:0];
    step_exp = (zero_cs || !root_nz) ? EXP_BITS'(STEP_ZERO_EXP)
                                     : EXP_BITS'(msb) - EXP_BITS'(EXP_BIAS);
    finite   = !zero_cs && !side_o.sat;
    risk     = !finite
            || (root > ROOT_BITS'(max_dist_r))
            || ((root == ROOT_BITS'(max_dist_r)) && rem_nz)
            || (root_nz && (msb > MSB_BITS'(RISK_MSB)));
    res = '0;
    res[OUT_BITS-1:0] = {risk, finite, step_exp, dist_val,
                         zero_cs ? REL_BITS'(0) : side_o.z,
                         zero_cs ? REL_BITS'(0) : side_o.y,
                         zero_cs ? REL_BITS'(0) : side_o.x};
  end

  // output register and skid entry
  always_comb begin
    take          = out_tready || !out_vld_r;
    push          = sq_vld && pipe_en;
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    skid_vld_nxt  = skid_vld_r;
    skid_data_nxt = skid_data_r;
    if (take) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = skid_data_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt  = push;
        out_data_nxt = res;
      end
    end else if (push) begin
      skid_vld_nxt  = 1'b1;
      skid_data_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held while output register empty");

  a_root_held: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_vld && !pipe_en) |=> sq_vld)
    else $error("root pipeline result lost during stall");

  a_finite_risk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_data_r[OUT_BITS-2]) |-> out_data_r[OUT_BITS-1])
    else $error("non-finite result without precision risk");

  a_zero_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (push && zero_cs) |-> (!finite && dist_val == '0))
    else $error("zero cell size produced a finite result");

endmodule

@@ sv/cro_axis_lane.sv @@
// cro_axis_lane: one axis of the offset, cell difference times cell size plus local difference
// five register stages; saturates to 48 bits and squares the magnitude; uses cro_pkg
module cro_axis_lane import cro_pkg::*; (
  input  logic                         clk,
  input  logic                         en,
  input  logic [CS_BITS-1:0]           cell_size,
  input  logic signed [CELL_BITS-1:0]  obj_cell,
  input  logic signed [CELL_BITS-1:0]  cam_cell,
  input  logic signed [LOCAL_BITS-1:0] obj_local,
  input  logic signed [LOCAL_BITS-1:0] cam_local,
  output logic signed [REL_BITS-1:0]   rel,
  output logic                         sat,
  output logic [SQ_BITS-1:0]           sq
);

  localparam logic signed [SUM_BITS-1:0] REL_HI =
    {{(SUM_BITS-REL_BITS+1){1'b0}}, {(REL_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] REL_LO =
    {{(SUM_BITS-REL_BITS+1){1'b1}}, {(REL_BITS-1){1'b0}}};
  localparam logic [63:0] CLAMP = 64'd1 << CLAMP_LOG2;

  // stage a
  logic signed [DC_BITS-1:0] dc;
  logic [DC_BITS-1:0]        mag_a_nxt, mag_a_r;
  logic                      neg_a_r;
  logic signed [LD_BITS-1:0] ld_a_nxt, ld_a_r;
  // stage b
  logic [PROD_BITS-1:0]      prod_b_nxt, prod_b_r;
  logic                      neg_b_r;
  logic signed [LD_BITS-1:0] ld_b_r;
  // stage c
  logic [63:0]                prod64;
  logic signed [SUM_BITS-1:0] pc, vc;
  logic signed [REL_BITS-1:0] rel_c_nxt, rel_c_r;
  logic                       sat_c_nxt, sat_c_r;
  // stage d
  logic [REL_BITS-1:0]        mag_d;
  logic [2*LO_BITS-1:0]       pll_d_r;
  logic [HI_BITS+LO_BITS-1:0] phl_d_r;
  logic [2*HI_BITS-1:0]       phh_d_r;
  logic signed [REL_BITS-1:0] rel_d_r;
  logic                       sat_d_r;
  // stage e
  logic [SQ_BITS-1:0]         sq_e_nxt, sq_e_r;
  logic signed [REL_BITS-1:0] rel_e_r;
  logic                       sat_e_r;

  always_comb begin
    dc        = DC_BITS'(obj_cell) - DC_BITS'(cam_cell);
    mag_a_nxt = dc[DC_BITS-1] ? DC_BITS'(-dc) : DC_BITS'(dc);
    ld_a_nxt  = LD_BITS'(obj_local) - LD_BITS'(cam_local);
  end

  always_comb begin
    prod_b_nxt = PROD_BITS'(mag_a_r) * PROD_BITS'(cell_size);
  end

  always_comb begin
    prod64 = 64'(prod_b_r);
    pc     = (prod64 > CLAMP) ? SUM_BITS'(CLAMP) : SUM_BITS'(prod64);
    vc     = (neg_b_r ? -pc : pc) + SUM_BITS'(ld_b_r);
    sat_c_nxt = 1'b0;
    rel_c_nxt = REL_BITS'(vc);
    if (vc > REL_HI) begin
      sat_c_nxt = 1'b1;
      rel_c_nxt = REL_BITS'(REL_HI);
    end else if (vc < REL_LO) begin
      sat_c_nxt = 1'b1;
      rel_c_nxt = REL_BITS'(REL_LO);
    end
  end

  always_comb begin
    mag_d = rel_c_r[REL_BITS-1] ? REL_BITS'(-rel_c_r) : REL_BITS'(rel_c_r);
  end

  // (hi*2^32 + lo)^2 from three partial products
  always_comb begin
    sq_e_nxt = (SQ_BITS'(phh_d_r) << (2 * LO_BITS))
             + (SQ_BITS'(phl_d_r) << (LO_BITS + 1))
             + SQ_BITS'(pll_d_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a_r  <= mag_a_nxt;
      neg_a_r  <= dc[DC_BITS-1];
      ld_a_r   <= ld_a_nxt;
      prod_b_r <= prod_b_nxt;
      neg_b_r  <= neg_a_r;
      ld_b_r   <= ld_a_r;
      rel_c_r  <= rel_c_nxt;
      sat_c_r  <= sat_c_nxt;
      pll_d_r  <= mag_d[LO_BITS-1:0] * mag_d[LO_BITS-1:0];
      phl_d_r  <= (HI_BITS+LO_BITS)'(mag_d[REL_BITS-1:LO_BITS])
                * (HI_BITS+LO_BITS)'(mag_d[LO_BITS-1:0]);
      phh_d_r  <= (2*HI_BITS)'(mag_d[REL_BITS-1:LO_BITS])
                * (2*HI_BITS)'(mag_d[REL_BITS-1:LO_BITS]);
      rel_d_r  <= rel_c_r;
      sat_d_r  <= sat_c_r;
      sq_e_r   <= sq_e_nxt;
      rel_e_r  <= rel_d_r;
      sat_e_r  <= sat_d_r;
    end
  end

  assign rel = rel_e_r;
  assign sat = sat_e_r;
  assign sq  = sq_e_r;

endmodule

@@ sv/cro_sqrt_pipe.sv @@
// cro_sqrt_pipe: pipelined integer square root, one root bit per stage
// keeps the remainder and the leading one position; uses cro_pkg
module cro_sqrt_pipe import cro_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [SQ_BITS-1:0]   radicand,
  input  side_t                in_side,
  output logic                 out_vld,
  output logic [ROOT_BITS-1:0] root,
  output logic                 rem_nz,
  output logic                 root_nz,
  output logic [MSB_BITS-1:0]  msb,
  output side_t                out_side
);

  logic                 vld_r  [0:ROOT_BITS];
  logic [RAD_BITS-1:0]  rad_r  [0:ROOT_BITS];
  logic [REM_BITS-1:0]  rem_r  [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] root_r [0:ROOT_BITS];
  logic                 nz_r   [0:ROOT_BITS];
  logic [MSB_BITS-1:0]  msb_r  [0:ROOT_BITS];
  side_t                side_r [0:ROOT_BITS];

  assign vld_r[0]  = in_vld;
  assign rad_r[0]  = RAD_BITS'(radicand);
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign nz_r[0]   = 1'b0;
  assign msb_r[0]  = '0;
  assign side_r[0] = in_side;

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    logic [REM_BITS-1:0] r2, trial, rem_nxt;
    logic                ge;

    always_comb begin
      r2      = {rem_r[k][REM_BITS-3:0], rad_r[k][RAD_BITS-1 -: 2]};
      trial   = REM_BITS'({root_r[k], 2'b01});
      ge      = (r2 >= trial);
      rem_nxt = ge ? (r2 - trial) : r2;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k+1]  <= rad_r[k] << 2;
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= {root_r[k][ROOT_BITS-2:0], ge};
        nz_r[k+1]   <= nz_r[k] | ge;
        // first set bit marks the leading one of the root
        msb_r[k+1]  <= (ge && !nz_r[k]) ? MSB_BITS'(ROOT_BITS - 1 - k) : msb_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_vld  = vld_r[ROOT_BITS];
  assign root     = root_r[ROOT_BITS];
  assign rem_nz   = (rem_r[ROOT_BITS] != '0);
  assign root_nz  = nz_r[ROOT_BITS];
  assign msb      = msb_r[ROOT_BITS];
  assign out_side = side_r[ROOT_BITS];

endmodule
